@@ design/prq_pkg.sv @@
// Shared types and codes for the priority request ring queue.
// Holds the controller state type, the command and status bundles and the result codes.
// No dependencies.
package prq_pkg;

  localparam int ID_W       = 32;
  localparam int PRI_PORT_W = 4;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_POP_WAIT,
    ST_FULL_CHK,
    ST_FULL_BEF,
    ST_SHIFT_INIT,
    ST_SHIFT_RD,
    ST_SHIFT_CHK,
    ST_INSERT,
    ST_RESULT
  } state_t;

  // Read address select for the entry RAM.
  typedef enum logic [1:0] {
    RD_HEAD,
    RD_NEWHEAD,
    RD_BEFORE,
    RD_NEXT
  } rd_sel_t;

  // Write select for the entry RAM.
  typedef enum logic [2:0] {
    WR_NONE,
    WR_APPEND,
    WR_BEFORE,
    WR_MOVE,
    WR_NEW
  } wr_sel_t;

  typedef struct packed {
    logic    capture;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    pop_take;
    logic    rej_full;
    logic    rej_empty;
    logic    evict_tail;
    logic    evict_keep;
    logic    evict_before;
    logic    shift_init;
    logic    shift_step;
    logic    count_inc;
    logic    load_out;
  } prq_cmd_t;

  typedef struct packed {
    logic op_pop;
    logic pri_zero;
    logic empty;
    logic full;
    logic rd_higher;
    logic rd_notify;
    logic pos_over;
    logic out_free;
  } prq_stat_t;

endpackage

@@ design/prq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Read-first on a same-address collision. No dependencies.
module prq_ram #(
  parameter int WIDTH = 37,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/prq_ctrl.sv @@
// Controller state machine for the priority request ring queue.
// Sequences pops, appends, eviction and the insertion shift. Depends on prq_pkg.
module prq_ctrl import prq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  prq_stat_t stat,
  output prq_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_HEAD;
    cmd.wr_sel = WR_NONE;
    in_ready   = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.op_pop) begin
          if (stat.empty) begin
            cmd.rej_empty = 1'b1;
            state_next    = ST_RESULT;
          end else begin
            cmd.rd_sel = RD_HEAD;
            state_next = ST_POP_WAIT;
          end
        end else if (stat.pri_zero) begin
          if (stat.full) begin
            cmd.rej_full = 1'b1;
          end else begin
            cmd.wr_sel    = WR_APPEND;
            cmd.count_inc = 1'b1;
          end
          state_next = ST_RESULT;
        end else if (stat.full) begin
          // The tail of a full ring sits just before the head.
          cmd.rd_sel = RD_NEWHEAD;
          state_next = ST_FULL_CHK;
        end else begin
          state_next = ST_SHIFT_INIT;
        end
      end
      ST_POP_WAIT: begin
        cmd.pop_take = 1'b1;
        state_next   = ST_RESULT;
      end
      ST_FULL_CHK: begin
        if (stat.rd_higher) begin
          cmd.rej_full = 1'b1;
          state_next   = ST_RESULT;
        end else if (stat.rd_notify) begin
          // A tail that wants notification survives; the entry before it goes.
          cmd.evict_keep = 1'b1;
          cmd.rd_sel     = RD_BEFORE;
          state_next     = ST_FULL_BEF;
        end else begin
          cmd.evict_tail = 1'b1;
          state_next     = ST_SHIFT_INIT;
        end
      end
      ST_FULL_BEF: begin
        cmd.evict_before = 1'b1;
        cmd.wr_sel       = WR_BEFORE;
        state_next       = ST_SHIFT_INIT;
      end
      ST_SHIFT_INIT: begin
        cmd.shift_init = 1'b1;
        state_next     = ST_SHIFT_RD;
      end
      ST_SHIFT_RD: begin
        if (stat.pos_over) begin
          state_next = ST_INSERT;
        end else begin
          cmd.rd_sel = RD_NEXT;
          state_next = ST_SHIFT_CHK;
        end
      end
      ST_SHIFT_CHK: begin
        if (stat.rd_higher) begin
          cmd.wr_sel     = WR_MOVE;
          cmd.shift_step = 1'b1;
          state_next     = ST_SHIFT_RD;
        end else begin
          state_next = ST_INSERT;
        end
      end
      ST_INSERT: begin
        cmd.wr_sel    = WR_NEW;
        cmd.count_inc = 1'b1;
        state_next    = ST_RESULT;
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/prq_dp.sv @@
// Datapath for the priority request ring queue: pointers, request and result
// registers, the output register and the entry RAM. Depends on prq_pkg and prq_ram.
module prq_dp import prq_pkg::*; #(
  parameter int QUEUE_DEPTH   = 256,
  parameter int PRIORITY_BITS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  prq_cmd_t              cmd,
  output prq_stat_t             stat,
  input  logic                  operation,
  input  logic [ID_W-1:0]       request_id,
  input  logic [PRI_PORT_W-1:0] request_priority,
  input  logic                  notify_flag,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            status,
  output logic                  popped_valid,
  output logic [ID_W-1:0]       popped_id,
  output logic [PRI_PORT_W-1:0] popped_priority,
  output logic                  popped_notify,
  output logic                  dropped_valid,
  output logic [ID_W-1:0]       dropped_id
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int EW = ID_W + PRIORITY_BITS + 1;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

  // Queue pointers.
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [AW-1:0] slot;
  logic [CW-1:0] pos;

  // Captured request.
  logic                     req_op;
  logic [ID_W-1:0]          req_id;
  logic [PRIORITY_BITS-1:0] req_pri;
  logic                     req_ntf;

  logic [EW-1:0] hold;

  // Result of the transaction in progress.
  status_t                  res_status;
  logic                     res_pv;
  logic [ID_W-1:0]          res_pid;
  logic [PRIORITY_BITS-1:0] res_ppri;
  logic                     res_pntf;
  logic                     res_dv;
  logic [ID_W-1:0]          res_did;

  // Output register.
  status_t                  out_status;
  logic [PRIORITY_BITS-1:0] out_ppri;

  // RAM port signals.
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [EW-1:0]            ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [EW-1:0]            ram_rdata;
  logic [ID_W-1:0]          rd_id;
  logic [PRIORITY_BITS-1:0] rd_pri;
  logic                     rd_ntf;

  logic [SW-1:0] tail_sum;
  logic [AW-1:0] tail_slot;
  logic [AW-1:0] newhead;
  logic [AW-1:0] prev_slot;

  assign rd_id  = ram_rdata[EW-1 -: ID_W];
  assign rd_pri = ram_rdata[1 +: PRIORITY_BITS];
  assign rd_ntf = ram_rdata[0];

  assign tail_sum  = SW'(head) + SW'(count);
  assign tail_slot = (tail_sum >= SW'(QUEUE_DEPTH)) ? AW'(tail_sum - SW'(QUEUE_DEPTH))
                                                    : AW'(tail_sum);
  assign newhead   = ptr_dec(head);
  assign prev_slot = ptr_dec(newhead);

  always_comb begin
    stat.op_pop    = (req_op == OP_POP);
    stat.pri_zero  = (req_pri == '0);
    stat.empty     = (count == '0);
    stat.full      = (count == CW'(QUEUE_DEPTH));
    stat.rd_higher = (rd_pri > req_pri);
    stat.rd_notify = rd_ntf;
    stat.pos_over  = (pos > count);
    stat.out_free  = !out_valid || out_ready;
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_HEAD:    ram_raddr = head;
      RD_NEWHEAD: ram_raddr = newhead;
      RD_BEFORE:  ram_raddr = prev_slot;
      RD_NEXT:    ram_raddr = ptr_inc(slot);
      default:    ram_raddr = head;
    endcase
  end

  always_comb begin
    ram_we    = 1'b1;
    ram_waddr = slot;
    ram_wdata = ram_rdata;
    case (cmd.wr_sel)
      WR_APPEND: begin
        ram_waddr = tail_slot;
        ram_wdata = {req_id, {PRIORITY_BITS{1'b0}}, req_ntf};
      end
      WR_BEFORE: begin
        ram_waddr = prev_slot;
        ram_wdata = hold;
      end
      WR_MOVE: begin
        ram_waddr = slot;
        ram_wdata = ram_rdata;
      end
      WR_NEW: begin
        ram_waddr = slot;
        ram_wdata = {req_id, req_pri, req_ntf};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  prq_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.pop_take) begin
        head <= ptr_inc(head);
      end else if (cmd.shift_init) begin
        head <= newhead;
      end

      if (cmd.pop_take) begin
        count <= count - 1'b1;
      end else if (cmd.evict_tail || cmd.evict_keep) begin
        count <= CW'(QUEUE_DEPTH - 1);
      end else if (cmd.count_inc) begin
        count <= count + 1'b1;
      end

      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op     <= operation;
      req_id     <= request_id;
      req_pri    <= PRIORITY_BITS'(request_priority);
      req_ntf    <= notify_flag;
      res_status <= STATUS_DONE;
      res_pv     <= 1'b0;
      res_pid    <= '0;
      res_ppri   <= '0;
      res_pntf   <= 1'b0;
      res_dv     <= 1'b0;
      res_did    <= '0;
    end
    if (cmd.rej_full) begin
      res_status <= STATUS_FULL;
    end
    if (cmd.rej_empty) begin
      res_status <= STATUS_EMPTY;
    end
    if (cmd.pop_take) begin
      res_pv   <= 1'b1;
      res_pid  <= rd_id;
      res_ppri <= rd_pri;
      res_pntf <= rd_ntf;
    end
    if (cmd.evict_tail) begin
      res_dv  <= 1'b1;
      res_did <= rd_id;
    end
    if (cmd.evict_keep) begin
      res_dv <= 1'b1;
      hold   <= ram_rdata;
    end
    if (cmd.evict_before) begin
      res_did <= rd_id;
    end
    if (cmd.shift_init) begin
      slot <= newhead;
      pos  <= CW'(1);
    end
    if (cmd.shift_step) begin
      slot <= ptr_inc(slot);
      pos  <= pos + 1'b1;
    end
    if (cmd.load_out) begin
      out_status    <= res_status;
      popped_valid  <= res_pv;
      popped_id     <= res_pid;
      out_ppri      <= res_ppri;
      popped_notify <= res_pntf;
      dropped_valid <= res_dv;
      dropped_id    <= res_did;
    end
  end

  assign status          = out_status;
  assign popped_priority = PRI_PORT_W'(out_ppri);

endmodule

@@ design/priority_request_ring_queue_unit.sv @@
// Top level of the priority request ring queue.
// Joins the controller (prq_ctrl) and the datapath (prq_dp). Depends on prq_pkg.

// One transaction at a time: every accepted request gives exactly one result. A push with
// nonzero priority walks the entry RAM from the head, one read and one write per entry it
// passes, and stops at the end of the ring or at the first entry of equal or lower
// priority. A push of nonzero priority into a full ring first evicts the tail, or the
// entry before the tail when the tail wants notification, and is rejected when the tail
// has strictly higher priority. The result sits in an output register, so the next
// request is accepted while it waits to be taken; a stalled result only holds the block
// at the end of the following transaction. The RAM needs no clearing after reset, since
// only reads of slots that hold live entries are ever used.
module priority_request_ring_queue_unit import prq_pkg::*; #(
  parameter int QUEUE_DEPTH   = 256,
  parameter int PRIORITY_BITS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  operation,
  input  logic [ID_W-1:0]       request_id,
  input  logic [PRI_PORT_W-1:0] request_priority,
  input  logic                  notify_flag,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            status,
  output logic                  popped_valid,
  output logic [ID_W-1:0]       popped_id,
  output logic [PRI_PORT_W-1:0] popped_priority,
  output logic                  popped_notify,
  output logic                  dropped_valid,
  output logic [ID_W-1:0]       dropped_id
);

  prq_cmd_t  cmd;
  prq_stat_t stat;

  prq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  prq_dp #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .operation       (operation),
    .request_id      (request_id),
    .request_priority(request_priority),
    .notify_flag     (notify_flag),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .popped_valid    (popped_valid),
    .popped_id       (popped_id),
    .popped_priority (popped_priority),
    .popped_notify   (popped_notify),
    .dropped_valid   (dropped_valid),
    .dropped_id      (dropped_id)
  );

endmodule

@@ design/prq_checker.sv @@
// Port-level checks for the priority request ring queue, bound to the top level.
// Depends on prq_pkg.
module prq_checker import prq_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [1:0]            status,
  input logic                  popped_valid,
  input logic [ID_W-1:0]       popped_id,
  input logic                  dropped_valid,
  input logic [ID_W-1:0]       dropped_id
);

  // Only one transaction is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) &&
                                   $stable(popped_id) && $stable(dropped_id)))
    else $error("stalled result changed");

  // A pop that returns an entry never evicts, and it reports success.
  a_pop_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && popped_valid) |-> (status == STATUS_DONE && !dropped_valid))
    else $error("pop result carries an eviction or an error code");

  // A failed transaction reports a known code and leaves both valid flags and both ids zero.
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_DONE) |->
      ((status == STATUS_FULL || status == STATUS_EMPTY) && !popped_valid &&
       !dropped_valid && popped_id == '0 && dropped_id == '0))
    else $error("failed transaction carries payload");

endmodule

bind priority_request_ring_queue_unit prq_checker u_prq_checker (.*);
